@@ src/tnsd_pkg.sv @@
// Shared constants and types for the triple normalize, sort and dedup unit.
`default_nettype none

package tnsd_pkg;

	// default parameter values
	localparam int CAPACITY_DEF   = 64;
	localparam int TAXON_BITS_DEF = 16;

	// fixed port widths and limits
	localparam int PORT_W      = 16;
	localparam int MAX_RESULTS = 64;
	localparam int DUP_W       = 6;
	localparam logic [DUP_W-1:0] DUP_MAX = '1;

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic insert;
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/triple_normalize_sort_dedup_unit.sv @@
// Top level: normalize, sort and deduplicate a set of index triples.
//
// Usage: present a triple on first_taxon, second_taxon, third_taxon with
// start high; the transaction is taken at a clock edge where busy is low.
// The first two indices are ordered on entry and the triple is inserted in
// sorted position in a chain of CAPACITY cells, one transaction per cycle
// while busy is low. A triple equal to one already held is counted as a
// duplicate and not kept. Items past the first CAPACITY of a set are
// dropped and flag overflow. A transaction with last_in_set high ends the
// set: from the next cycle busy is high and the unique triples leave in
// ascending order, one per cycle, each marked by result_strobe for one
// cycle. The receiver cannot stall. The final result has last_out high and
// carries duplicates_removed and overflow. At most 64 results are given,
// and any cut-off triples set overflow. The chain then clears in the last
// emit cycle and busy falls for the next set. Each kept triple enters by
// one chain insert step.
// Reset empties the chain and the counters; no results are pending.
`default_nettype none

module triple_normalize_sort_dedup_unit #(
	parameter int CAPACITY   = tnsd_pkg::CAPACITY_DEF,
	parameter int TAXON_BITS = tnsd_pkg::TAXON_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire  [tnsd_pkg::PORT_W-1:0]  first_taxon,
	input  wire  [tnsd_pkg::PORT_W-1:0]  second_taxon,
	input  wire  [tnsd_pkg::PORT_W-1:0]  third_taxon,
	input  wire                          last_in_set,
	output logic                         result_strobe,
	output logic [tnsd_pkg::PORT_W-1:0]  out_low_taxon,
	output logic [tnsd_pkg::PORT_W-1:0]  out_high_taxon,
	output logic [tnsd_pkg::PORT_W-1:0]  out_third_taxon,
	output logic                         last_out,
	output logic [tnsd_pkg::DUP_W-1:0]   duplicates_removed,
	output logic                         overflow
);

	localparam int PW     = tnsd_pkg::PORT_W;
	localparam int KW     = (TAXON_BITS < PW) ? TAXON_BITS : PW;
	localparam int KEY_W  = 3 * KW;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int EMIT_W = $clog2(tnsd_pkg::MAX_RESULTS);
	localparam int DW     = tnsd_pkg::DUP_W;

	logic                 busy_q;
	logic [CNT_W-1:0]     stored_q;
	logic                 ovf_q;
	logic [DW-1:0]        dup_q;
	logic [EMIT_W-1:0]    emitted_q;

	logic                 accept;
	logic                 has_room;
	logic                 any_equal;
	logic                 fin;
	logic                 fin_by_limit;
	logic [KW-1:0]        a_in;
	logic [KW-1:0]        b_in;
	logic [KW-1:0]        c_in;
	logic [KEY_W-1:0]     new_key;
	tnsd_pkg::cell_ctrl_t ctrl;

	logic [CAPACITY-1:0]  cell_valid;
	logic [CAPACITY-1:0]  cell_less;
	logic [CAPACITY-1:0]  cell_equal;
	logic [KEY_W-1:0]     cell_key [CAPACITY];

	// normalize the incoming triple: smaller of the first two goes first
	assign a_in    = KW'(first_taxon);
	assign b_in    = KW'(second_taxon);
	assign c_in    = KW'(third_taxon);
	assign new_key = (a_in < b_in) ? {a_in, b_in, c_in} : {b_in, a_in, c_in};

	assign accept    = start && !busy_q;
	assign has_room  = (stored_q < CNT_W'(CAPACITY));
	assign any_equal = |cell_equal;

	// end of the emit run: chain runs dry or the result limit is reached
	assign fin_by_limit = (emitted_q == EMIT_W'(tnsd_pkg::MAX_RESULTS - 1));
	assign fin          = !cell_valid[1] || fin_by_limit;

	// command for the chain this cycle
	always_comb begin
		ctrl.insert = accept && has_room && !any_equal;
		ctrl.shift  = busy_q && !fin;
		ctrl.clear  = busy_q && fin;
	end

	// row of cells linked to both neighbors; the end cells see an empty outer neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic             l_valid;
		logic [KEY_W-1:0] l_key;
		logic             l_less;
		logic             r_valid;
		logic [KEY_W-1:0] r_key;

		if (i == 0) begin : g_head
			assign l_valid = 1'b0;
			assign l_key   = '0;
			assign l_less  = 1'b0;
		end else begin : g_body
			assign l_valid = cell_valid[i-1];
			assign l_key   = cell_key[i-1];
			assign l_less  = cell_less[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_key   = '0;
		end else begin : g_link
			assign r_valid = cell_valid[i+1];
			assign r_key   = cell_key[i+1];
		end

		tnsd_cell #(
			.KEY_W(KEY_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_key    (new_key),
			.left_valid (l_valid),
			.left_key   (l_key),
			.left_less  (l_less),
			.right_valid(r_valid),
			.right_key  (r_key),
			.valid      (cell_valid[i]),
			.key        (cell_key[i]),
			.less       (cell_less[i]),
			.equal      (cell_equal[i])
		);
	end

	// set bookkeeping: fill count, duplicates, overflow, emit phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			stored_q  <= '0;
			ovf_q     <= 1'b0;
			dup_q     <= '0;
			emitted_q <= '0;
		end else if (busy_q) begin
			if (fin) begin
				busy_q   <= 1'b0;
				stored_q <= '0;
				ovf_q    <= 1'b0;
				dup_q    <= '0;
			end
			emitted_q <= emitted_q + EMIT_W'(1);
		end else if (accept) begin
			if (has_room) begin
				stored_q <= stored_q + CNT_W'(1);
				if (any_equal && dup_q != tnsd_pkg::DUP_MAX) begin
					dup_q <= dup_q + DW'(1);
				end
			end else begin
				ovf_q <= 1'b1;
			end
			if (last_in_set) begin
				busy_q    <= 1'b1;
				emitted_q <= '0;
			end
		end
	end

	// result ports: taxa straight from the head cell, flags from the set bookkeeping
	assign busy               = busy_q;
	assign result_strobe      = busy_q;
	assign out_low_taxon      = PW'(cell_key[0][KEY_W-1 -: KW]);
	assign out_high_taxon     = PW'(cell_key[0][2*KW-1 -: KW]);
	assign out_third_taxon    = PW'(cell_key[0][KW-1:0]);
	assign last_out           = busy_q && fin;
	assign duplicates_removed = (busy_q && fin) ? dup_q : '0;
	assign overflow           = busy_q && fin &&
	                            (ovf_q || (fin_by_limit && cell_valid[1]));

endmodule

`default_nettype wire

@@ src/tnsd_cell.sv @@
// One cell of the sorted insertion chain: holds one triple key and its valid bit.
`default_nettype none

module tnsd_cell #(
	parameter int KEY_W = 48
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  tnsd_pkg::cell_ctrl_t    ctrl,
	input  wire  [KEY_W-1:0]        new_key,
	input  wire                     left_valid,
	input  wire  [KEY_W-1:0]        left_key,
	input  wire                     left_less,
	input  wire                     right_valid,
	input  wire  [KEY_W-1:0]        right_key,
	output logic                    valid,
	output logic [KEY_W-1:0]        key,
	output logic                    less,
	output logic                    equal
);

	logic             valid_q;
	logic [KEY_W-1:0] key_q;

	// compare the broadcast key against the held one; an empty cell sorts last
	assign less  = !valid_q || (new_key < key_q);
	assign equal = valid_q && (new_key == key_q);
	assign valid = valid_q;
	assign key   = key_q;

	// valid bit: clear, take the new key, take the left neighbor, or advance from the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert && less) begin
			valid_q <= left_less ? left_valid : 1'b1;
		end else if (ctrl.shift) begin
			valid_q <= right_valid;
		end
	end

	// key payload follows the same selection, without clear or reset
	always_ff @(posedge clk) begin
		if (ctrl.insert && less) begin
			key_q <= left_less ? left_key : new_key;
		end else if (ctrl.shift) begin
			key_q <= right_key;
		end
	end

endmodule

`default_nettype wire

@@ src/tnsd_checker.sv @@
// Port-level checker for the triple unit, bound to the top level.
`default_nettype none

module tnsd_checker (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire busy,
	input wire last_in_set,
	input wire result_strobe,
	input wire last_out
);

	// results appear only during the emit phase
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy)
		else $error("result strobe outside emit phase");

	// the final marker rides on a result
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_out |-> result_strobe)
		else $error("last_out without a result");

	// an emit run has no gaps until its final result
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last_out) |=> result_strobe)
		else $error("gap inside an emit run");

	// the unit is free right after the final result
	a_free_after: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last_out) |=> !busy)
		else $error("busy held after the final result");

	// closing a set starts the emit phase
	a_close_set: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_in_set) |=> (busy && result_strobe))
		else $error("set close did not start emitting");

endmodule

bind triple_normalize_sort_dedup_unit tnsd_checker u_tnsd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last_in_set  (last_in_set),
	.result_strobe(result_strobe),
	.last_out     (last_out)
);

`default_nettype wire

@@ tb/triple_normalize_sort_dedup_unit_test.sv @@
// Testbench for the triple normalize, sort and dedup unit: directed and random sets.
`timescale 1ns / 1ps

module triple_normalize_sort_dedup_unit_test;

	localparam int CAP = tnsd_pkg::CAPACITY_DEF;
	localparam int TW  = tnsd_pkg::TAXON_BITS_DEF;
	localparam int PW  = tnsd_pkg::PORT_W;
	localparam int DW  = tnsd_pkg::DUP_W;
	localparam int MAX_RES = tnsd_pkg::MAX_RESULTS;
	localparam logic [PW-1:0] TAXON_MASK = PW'((64'd1 << TW) - 1);

	typedef enum int {POOL_WIDE, POOL_NARROW, POOL_EDGE} taxon_pool_t;

	typedef struct packed {
		logic [PW-1:0] lo;
		logic [PW-1:0] hi;
		logic [PW-1:0] th;
	} triple_t;

	typedef struct packed {
		logic [PW-1:0]    lo;
		logic [PW-1:0]    hi;
		logic [PW-1:0]    th;
		logic             fin;
		logic [DW-1:0]    dups;
		logic             ovf;
	} unique_result_t;

	// block ports
	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [PW-1:0]    first_taxon = '0;
	logic [PW-1:0]    second_taxon = '0;
	logic [PW-1:0]    third_taxon = '0;
	logic             last_in_set = 1'b0;
	logic             busy;
	logic             result_strobe;
	logic [PW-1:0]    out_low_taxon;
	logic [PW-1:0]    out_high_taxon;
	logic [PW-1:0]    out_third_taxon;
	logic             last_out;
	logic [DW-1:0]    duplicates_removed;
	logic             overflow;

	// predictor state and expected results
	triple_t        held_triples [CAP];
	int             held_count = 0;
	bit             held_ovf = 1'b0;
	unique_result_t expected_uniques [$];

	// run statistics
	int  errors = 0;
	int  items_sent = 0;
	int  sets_done = 0;
	int  results_seen = 0;
	int  overflow_sets = 0;
	bit  no_idle = 1'b0;

	triple_normalize_sort_dedup_unit DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.first_taxon        (first_taxon),
		.second_taxon       (second_taxon),
		.third_taxon        (third_taxon),
		.last_in_set        (last_in_set),
		.result_strobe      (result_strobe),
		.out_low_taxon      (out_low_taxon),
		.out_high_taxon     (out_high_taxon),
		.out_third_taxon    (out_third_taxon),
		.last_out           (last_out),
		.duplicates_removed (duplicates_removed),
		.overflow           (overflow)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Store one accepted triple; on the last of a set, sort, drop duplicates
	// and queue the unique triples in ascending order.
	function automatic void absorb_triple(input logic [PW-1:0] a, input logic [PW-1:0] b,
		input logic [PW-1:0] c, input bit last);
		logic [PW-1:0] ma;
		logic [PW-1:0] mb;
		triple_t       key;
		triple_t       sorted_set [CAP];
		int            n;
		int            j;
		int            uniq;
		int            dups;
		int            emitted;
		bit            ovf;
		unique_result_t r;
		ma = a & TAXON_MASK;
		mb = b & TAXON_MASK;
		if (held_count < CAP) begin
			held_triples[held_count].lo = (ma < mb) ? ma : mb;
			held_triples[held_count].hi = (ma < mb) ? mb : ma;
			held_triples[held_count].th = c & TAXON_MASK;
			held_count++;
		end else begin
			held_ovf = 1'b1;
		end
		if (!last)
			return;

		// insertion sort on the packed (low, high, third) key
		n = held_count;
		for (int i = 0; i < n; i++)
			sorted_set[i] = held_triples[i];
		for (int i = 1; i < n; i++) begin
			key = sorted_set[i];
			j = i;
			while (j > 0 && key < sorted_set[j-1]) begin
				sorted_set[j] = sorted_set[j-1];
				j--;
			end
			sorted_set[j] = key;
		end

		// compact unique entries to the front
		uniq = 0;
		for (int i = 0; i < n; i++) begin
			if (uniq == 0 || sorted_set[i] != sorted_set[uniq-1]) begin
				sorted_set[uniq] = sorted_set[i];
				uniq++;
			end
		end
		dups = n - uniq;
		if (dups > int'(tnsd_pkg::DUP_MAX))
			dups = int'(tnsd_pkg::DUP_MAX);
		ovf = held_ovf;
		emitted = uniq;
		if (emitted > MAX_RES) begin
			emitted = MAX_RES;
			ovf = 1'b1;
		end
		if (ovf)
			overflow_sets++;

		if (emitted == 0) begin
			r = '0;
			r.fin = 1'b1;
			r.dups = DW'(dups);
			r.ovf = ovf;
			expected_uniques.push_back(r);
		end else begin
			for (int i = 0; i < emitted; i++) begin
				r.lo = sorted_set[i].lo;
				r.hi = sorted_set[i].hi;
				r.th = sorted_set[i].th;
				r.fin = (i == emitted - 1);
				r.dups = r.fin ? DW'(dups) : '0;
				r.ovf = r.fin && ovf;
				expected_uniques.push_back(r);
			end
		end
		held_count = 0;
		held_ovf = 1'b0;
		sets_done++;
	endfunction

	function automatic logic [PW-1:0] pick_taxon(input taxon_pool_t pool);
		case (pool)
			POOL_WIDE:   return PW'($urandom);
			POOL_NARROW: return PW'($urandom_range(0, 3));
			default: begin
				case ($urandom_range(0, 3))
					0:       return '0;
					1:       return '1;
					2:       return ~PW'($urandom_range(0, 2));
					default: return PW'($urandom_range(0, 2));
				endcase
			end
		endcase
	endfunction

	// Drive one transaction, after a random gap unless no_idle, and hold it until taken.
	task automatic send_triple(input logic [PW-1:0] a, input logic [PW-1:0] b,
		input logic [PW-1:0] c, input bit last);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			start <= 1'b0;
			first_taxon <= PW'($urandom);
			second_taxon <= PW'($urandom);
			third_taxon <= PW'($urandom);
			last_in_set <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		first_taxon <= a;
		second_taxon <= b;
		third_taxon <= c;
		last_in_set <= last;
		do
			@(posedge clk);
		while (busy);
		absorb_triple(a, b, c, last);
		items_sent++;
	endtask

	task automatic send_set(input int len, input taxon_pool_t pool);
		for (int i = 0; i < len; i++)
			send_triple(pick_taxon(pool), pick_taxon(pool), pick_taxon(pool), i == len - 1);
	endtask

	// Hold off the sender until every queued result has come out.
	task automatic wait_for_drain();
		start <= 1'b0;
		while (expected_uniques.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_lone_triples();
		send_triple(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
		send_triple(16'h0000, 16'h0000, 16'h0000, 1'b1);
		send_triple(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		wait_for_drain();
	endtask

	task automatic test_swap_and_sort();
		send_triple(16'd5, 16'd3, 16'd9, 1'b0);
		send_triple(16'd1, 16'd2, 16'd3, 1'b0);
		send_triple(16'hFFFF, 16'h0000, 16'd1, 1'b0);
		send_triple(16'd2, 16'd1, 16'd0, 1'b0);
		send_triple(16'd3, 16'd5, 16'd8, 1'b1);
		wait_for_drain();
	endtask

	task automatic test_duplicates();
		// swapped copies count as duplicates, a different third does not
		send_triple(16'd7, 16'd4, 16'd2, 1'b0);
		send_triple(16'd4, 16'd7, 16'd2, 1'b0);
		send_triple(16'd4, 16'd7, 16'd2, 1'b0);
		send_triple(16'd4, 16'd7, 16'd3, 1'b0);
		send_triple(16'd7, 16'd4, 16'd2, 1'b1);
		// whole set identical
		for (int i = 0; i < 4; i++)
			send_triple(16'hAAAA, 16'h5555, 16'h5555, i == 3);
		wait_for_drain();
	endtask

	task automatic test_store_full();
		// exactly full, mostly unique: the longest emit run
		no_idle = 1'b1;
		send_set(CAP, POOL_WIDE);
		wait_for_drain();
		// two past full, the marked item itself dropped
		no_idle = 1'b0;
		send_set(CAP + 2, POOL_NARROW);
		wait_for_drain();
	endtask

	task automatic test_random_sets();
		int len;
		taxon_pool_t pool;
		while (items_sent < 270) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
			pool = taxon_pool_t'($urandom_range(0, 2));
			no_idle = ($urandom_range(0, 3) == 0);
			send_set(len, pool);
			if ($urandom_range(0, 3) == 0)
				wait_for_drain();
		end
		no_idle = 1'b0;
	endtask

	// Compare each result against the oldest expected unique triple.
	always @(posedge clk) begin : check_results
		unique_result_t exp_r;
		if (arst_n && result_strobe) begin
			results_seen++;
			if (expected_uniques.size() == 0) begin
				errors++;
				$display("%0t: result %h %h %h with nothing expected", $time,
					out_low_taxon, out_high_taxon, out_third_taxon);
			end else begin
				exp_r = expected_uniques.pop_front();
				if (out_low_taxon !== exp_r.lo) begin
					errors++;
					$display("%0t: out_low_taxon expected %h actual %h", $time,
						exp_r.lo, out_low_taxon);
				end
				if (out_high_taxon !== exp_r.hi) begin
					errors++;
					$display("%0t: out_high_taxon expected %h actual %h", $time,
						exp_r.hi, out_high_taxon);
				end
				if (out_third_taxon !== exp_r.th) begin
					errors++;
					$display("%0t: out_third_taxon expected %h actual %h", $time,
						exp_r.th, out_third_taxon);
				end
				if (last_out !== exp_r.fin) begin
					errors++;
					$display("%0t: last_out expected %b actual %b", $time, exp_r.fin, last_out);
				end
				if (duplicates_removed !== exp_r.dups) begin
					errors++;
					$display("%0t: duplicates_removed expected %0d actual %0d", $time,
						exp_r.dups, duplicates_removed);
				end
				if (overflow !== exp_r.ovf) begin
					errors++;
					$display("%0t: overflow expected %b actual %b", $time, exp_r.ovf, overflow);
				end
			end
		end
	end

	// Sequence the tests after reset.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_lone_triples();
		test_swap_and_sort();
		test_duplicates();
		test_store_full();
		test_random_sets();
		wait_for_drain();
		repeat (8) @(posedge clk);
		$display("Covered %0d sets from %0d triples, %0d results checked, %0d sets with overflow",
			sets_done, items_sent, results_seen, overflow_sets);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Stop a hung run.
	initial begin
		#2_000_000;
		$display("Timeout with %0d results still expected", expected_uniques.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ triple_normalize_sort_dedup_unit.f @@
src/tnsd_pkg.sv
src/tnsd_cell.sv
src/triple_normalize_sort_dedup_unit.sv
src/tnsd_checker.sv
tb/triple_normalize_sort_dedup_unit_test.sv
